// ----- rtl/rvm_pkg.sv -----
// Shared types and constants for the rolling volatility multiplier.
// No dependencies; imported by rolling_volatility_multiplier.
`default_nettype none

package rvm_pkg;

  localparam int SYMBOLS_DEF    = 16;
  localparam int WINDOW_MAX_DEF = 64;

  localparam logic [23:0] ONE_Q16        = 24'd65536;
  localparam logic [6:0]  WINDOW_RST     = 7'd20;
  localparam logic [19:0] LAMBDA_RST     = 20'd32768;
  localparam logic [23:0] MIN_MULT_RST   = 24'd32768;
  localparam logic [23:0] MAX_MULT_RST   = 24'd131072;

  typedef enum logic [1:0] {
    FN_APPEND    = 2'd0,
    FN_QUERY     = 2'd1,
    FN_CLEAR     = 2'd2,
    FN_CLEAR_ALL = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_WINDOW   = 2'd0,
    REG_LAMBDA   = 2'd1,
    REG_MIN_MULT = 2'd2,
    REG_MAX_MULT = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_MDIV,
    ST_SQ,
    ST_VDIV,
    ST_SQRT,
    ST_ZSC,
    ST_GAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [3:0]         symbol_index;
    logic signed [31:0] return_value;
  } request_t;

  typedef struct packed {
    logic [23:0] multiplier;
    logic        default_used;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/rolling_volatility_multiplier.sv -----
// Top level of the rolling volatility multiplier: ring memory, sequencer, divider, square root.
// Depends on rvm_pkg.
`default_nettype none

// Rolling volatility multiplier. Each item accepted (start high, busy low) names a symbol and
// an operation. Append, clear symbol and clear all take effect on acceptance and give no result.
// A query on an out-of-range symbol or one with fewer than two stored returns gives 1.0 with
// default_used set, in the cycle after acceptance. A full query walks the symbol's ring in the
// return memory twice, one read a cycle (sum, then squared deviations), runs a one-bit-a-cycle
// divider for the mean (40 steps) and for the variance (64 steps), and a two-bit-a-cycle square
// root (32 steps): busy stays high through the query, and the result comes in the first cycle
// with busy low again. The result sits on result for exactly one cycle with done high; the
// receiver cannot stall it. Configuration is written through cfg_valid/cfg_ready while the
// block is idle; shortening window_length trims every symbol's history at once.
module rolling_volatility_multiplier
  import rvm_pkg::*;
#(
  parameter int SYMBOLS    = SYMBOLS_DEF,
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire request_t request,
  output logic          done,
  output result_t       result,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire cfg_reg_t cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int SW    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int HW    = $clog2(WINDOW_MAX);
  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int DEPTH = SYMBOLS * WINDOW_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUMW  = 33 + HW;
  localparam int MIT   = SUMW + 1;
  localparam int MSH   = 64 - MIT;

  // Configuration registers
  logic [6:0]  window_length;
  logic [19:0] gain_lambda;
  logic [23:0] mult_floor;
  logic [23:0] mult_ceiling;

  // Per-symbol ring pointers
  logic [HW-1:0] head  [SYMBOLS];
  logic [CW-1:0] count [SYMBOLS];

  // Return memory
  logic signed [31:0] ring [DEPTH];
  logic signed [31:0] rd_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;

  state_t state, state_next;

  // Query context
  logic [AW-1:0]  q_base;
  logic [HW-1:0]  q_pos;
  logic [CW-1:0]  q_n;
  logic [CW-1:0]  iss;
  logic [CW-1:0]  got;
  logic           rd_vld;
  logic signed [SUMW-1:0] sum;
  logic [63:0]    sq;
  logic           sq_vld;
  logic [63:0]    acc;

  // Shared divider and root
  logic [CW-1:0]  dv_rem;
  logic [63:0]    dv_quo;
  logic [CW-1:0]  dv_div;
  logic [6:0]     cnt;
  logic [33:0]    rt_rem;
  logic [31:0]    rt_root;

  logic signed [32:0] zsc;
  logic signed [53:0] prod;

  function automatic logic [CW-1:0] eff_win(input logic [6:0] wl);
    logic [CW-1:0] w;
    begin
      if (wl < 7'd2) begin
        w = CW'(2);
      end else if (32'(wl) > WINDOW_MAX) begin
        w = CW'(WINDOW_MAX);
      end else begin
        w = CW'(wl);
      end
      return w;
    end
  endfunction

  logic               accept;
  logic               sym_ok;
  logic [SW-1:0]      sym;
  logic [CW-1:0]      win;
  logic [HW-1:0]      pos_prev;
  logic signed [SUMW-1:0] sum_add;
  logic [SUMW-1:0]    sum_mag;
  logic signed [32:0] mean;
  logic signed [33:0] dev;
  logic [33:0]        dev_abs;
  logic [64:0]        acc_add;
  logic [63:0]        acc_sat;
  logic [CW:0]        dv_sh;
  logic               dv_ge;
  logic [63:0]        dv_quo_next;
  logic [CW-1:0]      dv_rem_next;
  logic [33:0]        rt_sh;
  logic [33:0]        rt_trial;
  logic [41:0]        z_scaled;
  logic signed [42:0] z_raw;
  logic [53:0]        prod_mag;
  logic [23:0]        delta;
  logic signed [25:0] m_raw;
  logic [23:0]        m_out;

  always_comb begin
    accept   = start && !busy;
    sym      = SW'(request.symbol_index);
    sym_ok   = 32'(request.symbol_index) < SYMBOLS;
    win      = eff_win(window_length);
    pos_prev = (q_pos == '0) ? HW'(WINDOW_MAX - 1) : q_pos - 1'b1;
    rd_en    = (state == ST_SUM || state == ST_SQ) && (iss != q_n);
    rd_addr  = q_base + AW'(pos_prev);
    wr_en    = accept && request.func == FN_APPEND && sym_ok;
    wr_addr  = AW'(sym * WINDOW_MAX) + AW'(head[sym]);

    sum_add  = sum + SUMW'(rd_data);
    sum_mag  = sum_add[SUMW-1] ? SUMW'(-sum_add) : sum_add;

    // mean = quotient, rounded half away from zero, signed as the sum
    mean     = sum[SUMW-1] ? -$signed({1'b0, dv_quo[31:0]}) : $signed({1'b0, dv_quo[31:0]});
    dev      = 34'(rd_data) - 34'(mean);
    dev_abs  = dev[33] ? 34'(-dev) : dev;
    acc_add  = {1'b0, acc} + {1'b0, sq};
    acc_sat  = acc_add[64] ? '1 : acc_add[63:0];

    dv_sh       = {dv_rem, dv_quo[63]};
    dv_ge       = dv_sh >= {1'b0, dv_div};
    dv_rem_next = dv_ge ? CW'(dv_sh - {1'b0, dv_div}) : dv_sh[CW-1:0];
    dv_quo_next = {dv_quo[62:0], dv_ge};

    rt_sh    = {rt_rem[31:0], dv_quo[63:62]};
    rt_trial = {rt_root, 2'b01};

    z_scaled = 42'(rt_root) * 42'd200;
    z_raw    = $signed({1'b0, z_scaled}) - 43'sd2147483648;

    prod_mag = prod[53] ? 54'(-prod) : prod;
    delta    = 24'((prod_mag + 54'd536870912) >> 30);
    m_raw    = prod[53] ? 26'sd65536 - $signed({2'b0, delta})
                        : 26'sd65536 + $signed({2'b0, delta});
    // upper clamp first, so crossed bounds give the lower one
    if (m_raw > $signed({2'b0, mult_ceiling})) begin
      m_out = mult_ceiling;
    end else begin
      m_out = m_raw[23:0];
    end
    if (m_raw > $signed({2'b0, mult_ceiling})) begin
      if (mult_ceiling < mult_floor) m_out = mult_floor;
    end else if (m_raw < $signed({2'b0, mult_floor})) begin
      m_out = mult_floor;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = state != ST_IDLE;
    cfg_ready  = state == ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (accept && request.func == FN_QUERY && sym_ok && count[sym] >= CW'(2)) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM:  if (rd_vld && got == q_n - 1'b1) state_next = ST_MDIV;
      ST_MDIV: if (cnt == 7'd1) state_next = ST_SQ;
      ST_SQ:   if (sq_vld && got == q_n - 1'b1) state_next = ST_VDIV;
      ST_VDIV: if (cnt == 7'd1) state_next = ST_SQRT;
      ST_SQRT: if (cnt == 7'd1) state_next = ST_ZSC;
      ST_ZSC:  state_next = ST_GAIN;
      ST_GAIN: state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Return memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) ring[wr_addr] <= request.return_value;
    if (rd_en) rd_data <= ring[rd_addr];
  end

  // Configuration and ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RST;
      gain_lambda   <= LAMBDA_RST;
      mult_floor    <= MIN_MULT_RST;
      mult_ceiling  <= MAX_MULT_RST;
      for (int s = 0; s < SYMBOLS; s++) begin
        head[s]  <= '0;
        count[s] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WINDOW: begin
            window_length <= cfg_data[6:0];
            // trim every history to the new window, keeping the newest items
            for (int s = 0; s < SYMBOLS; s++) begin
              if (count[s] > eff_win(cfg_data[6:0])) count[s] <= eff_win(cfg_data[6:0]);
            end
          end
          REG_LAMBDA:   gain_lambda  <= cfg_data[19:0];
          REG_MIN_MULT: mult_floor   <= cfg_data;
          REG_MAX_MULT: mult_ceiling <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        unique case (request.func)
          FN_APPEND: begin
            if (sym_ok) begin
              head[sym] <= (32'(head[sym]) + 1 >= WINDOW_MAX) ? '0 : head[sym] + 1'b1;
              if (count[sym] < win) count[sym] <= count[sym] + 1'b1;
              else count[sym] <= win;
            end
          end
          FN_CLEAR: begin
            if (sym_ok) begin
              head[sym]  <= '0;
              count[sym] <= '0;
            end
          end
          FN_CLEAR_ALL: begin
            for (int s = 0; s < SYMBOLS; s++) begin
              head[s]  <= '0;
              count[s] <= '0;
            end
          end
          FN_QUERY: ;
          default: ;
        endcase
      end
    end
  end

  // Query datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      sq_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      sq_vld <= rd_vld && state == ST_SQ;
      done   <= 1'b0;
      if (rd_en) begin
        q_pos <= pos_prev;
        iss   <= iss + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          q_base <= AW'(sym * WINDOW_MAX);
          q_pos  <= head[sym];
          q_n    <= count[sym];
          iss    <= '0;
          got    <= '0;
          sum    <= '0;
          acc    <= '0;
          if (accept && request.func == FN_QUERY
              && !(sym_ok && count[sym] >= CW'(2))) begin
            done                <= 1'b1;
            result.multiplier   <= ONE_Q16;
            result.default_used <= 1'b1;
          end
        end
        ST_SUM: begin
          if (rd_vld) begin
            sum <= sum_add;
            got <= got + 1'b1;
            if (got == q_n - 1'b1) begin
              // load |sum| + n/2 into the top of the divider
              dv_quo <= 64'(64'(sum_mag) + 64'(q_n >> 1)) << MSH;
              dv_rem <= '0;
              dv_div <= q_n;
              cnt    <= 7'(MIT);
            end
          end
        end
        ST_MDIV: begin
          dv_rem <= dv_rem_next;
          dv_quo <= dv_quo_next;
          cnt    <= cnt - 1'b1;
          if (cnt == 7'd1) begin
            iss   <= '0;
            got   <= '0;
            q_pos <= q_base[HW-1:0] ^ q_base[HW-1:0] ^ head[q_base / WINDOW_MAX];
          end
        end
        ST_SQ: begin
          if (rd_vld) sq <= 64'(dev_abs[31:0]) * 64'(dev_abs[31:0]);
          if (sq_vld) begin
            acc <= acc_sat;
            got <= got + 1'b1;
            if (got == q_n - 1'b1) begin
              dv_quo <= acc_sat;
              dv_rem <= '0;
              dv_div <= q_n - 1'b1;
              cnt    <= 7'd64;
            end
          end
        end
        ST_VDIV: begin
          dv_rem <= dv_rem_next;
          dv_quo <= dv_quo_next;
          cnt    <= cnt - 1'b1;
          if (cnt == 7'd1) begin
            rt_rem  <= '0;
            rt_root <= '0;
            cnt     <= 7'd32;
          end
        end
        ST_SQRT: begin
          // two radicand bits a step, taken from the top of the quotient register
          dv_quo <= {dv_quo[61:0], 2'b00};
          cnt    <= cnt - 1'b1;
          if (rt_sh >= rt_trial) begin
            rt_rem  <= rt_sh - rt_trial;
            rt_root <= {rt_root[30:0], 1'b1};
          end else begin
            rt_rem  <= rt_sh;
            rt_root <= {rt_root[30:0], 1'b0};
          end
        end
        ST_ZSC: begin
          if (z_raw > 43'sd2147483648) zsc <= 33'sd2147483647 + 33'sd1;
          else zsc <= 33'(z_raw);
        end
        ST_GAIN: begin
          prod <= $signed({1'b0, gain_lambda}) * zsc;
        end
        ST_FIN: begin
          done                <= 1'b1;
          result.multiplier   <= m_out;
          result.default_used <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- dv/rolling_volatility_multiplier_test.sv -----
// Self-checking testbench for rolling_volatility_multiplier: append/query/clear items with
// per-symbol return histories predicted alongside the block. Depends on rvm_pkg and the RTL.
`default_nettype none

module rolling_volatility_multiplier_test
  import rvm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSYM       = 16;
  localparam int WMAX       = 64;
  localparam int STALL_MAX  = 5000;  // idle cycles tolerated

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  request_t request = '0;
  logic     done;
  result_t  result;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_reg_t cfg_index = REG_WINDOW;
  logic [23:0] cfg_data = '0;

  rolling_volatility_multiplier u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the block: return histories and configuration.
  longint      hist_ring [NSYM][WMAX];
  int unsigned hist_head [NSYM];
  int unsigned hist_count [NSYM];
  logic [6:0]  window_len;
  logic [19:0] lambda_q16;
  logic [23:0] min_mult;
  logic [23:0] max_mult;

  result_t expected_results[$];
  int      mismatches = 0;
  bit      no_idle = 1'b0;
  int      quiet_cycles = 0;

  function automatic int unsigned live_window();
    int unsigned w;
    w = window_len;
    if (w < 2) w = 2;
    if (w > WMAX) w = WMAX;
    return w;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [127:0] root, trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= {64'd0, v}) root = trial;
    end
    return root[63:0];
  endfunction

  // Multiplier for one symbol from its newest hist_count returns.
  function automatic result_t multiplier_of(int unsigned sym);
    result_t     r;
    int unsigned n, pos;
    longint      total, mean, dev, z, prod, m;
    logic [63:0] mag, q, var_q60, sigma;
    logic [127:0] acc, sq;
    n = hist_count[sym];
    r.multiplier = ONE_Q16;
    r.default_used = 1'b1;
    if (n < 2) return r;
    r.default_used = 1'b0;
    total = 0;
    pos = hist_head[sym];
    for (int k = 0; k < n; k++) begin
      pos = (pos == 0) ? WMAX - 1 : pos - 1;
      total += hist_ring[sym][pos];
    end
    mag = (total < 0) ? -total : total;
    q = (mag + n / 2) / n;
    mean = (total < 0) ? -longint'(q) : longint'(q);
    acc = '0;
    pos = hist_head[sym];
    for (int k = 0; k < n; k++) begin
      pos = (pos == 0) ? WMAX - 1 : pos - 1;
      dev = hist_ring[sym][pos] - mean;
      mag = (dev < 0) ? -dev : dev;
      sq = {64'd0, mag} * {64'd0, mag};
      acc = acc + sq;
      if (acc > {64'd0, {64{1'b1}}}) acc = {64'd0, {64{1'b1}}};  // saturate at 2^64-1
    end
    var_q60 = acc[63:0] / (n - 1);
    sigma = floor_sqrt(var_q60);
    z = 200 * longint'(sigma) - (64'sd1 <<< 31);
    if (z > (64'sd1 <<< 31)) z = 64'sd1 <<< 31;
    if (z < -(64'sd1 <<< 31)) z = -(64'sd1 <<< 31);
    prod = longint'({44'd0, lambda_q16}) * z;
    mag = (prod < 0) ? -prod : prod;
    q = (mag + (64'd1 << 29)) >> 30;
    m = 65536 + ((prod < 0) ? -longint'(q) : longint'(q));
    // Upper clamp first, so crossed bounds give min_mult.
    if (m > longint'({40'd0, max_mult})) m = max_mult;
    if (m < longint'({40'd0, min_mult})) m = min_mult;
    r.multiplier = m[23:0];
    return r;
  endfunction

  // Advance the shadow state for one accepted item; queue any expected result.
  task automatic apply_item(request_t req);
    int unsigned s;
    s = req.symbol_index;
    case (req.func)
      FN_APPEND: begin
        hist_ring[s][hist_head[s]] = longint'(req.return_value);
        hist_head[s] = (hist_head[s] + 1 >= WMAX) ? 0 : hist_head[s] + 1;
        if (hist_count[s] < live_window()) hist_count[s]++;
        if (hist_count[s] > live_window()) hist_count[s] = live_window();
      end
      FN_QUERY: expected_results.insert(expected_results.size(), multiplier_of(s));
      FN_CLEAR: begin
        hist_head[s] = 0;
        hist_count[s] = 0;
      end
      default: begin
        for (int i = 0; i < NSYM; i++) begin
          hist_head[i] = 0;
          hist_count[i] = 0;
        end
      end
    endcase
  endtask

  task automatic apply_cfg(cfg_reg_t idx, logic [23:0] data);
    case (idx)
      REG_WINDOW: begin
        window_len = data[6:0];
        // Trim every history to the new window at once.
        for (int i = 0; i < NSYM; i++)
          if (hist_count[i] > live_window()) hist_count[i] = live_window();
      end
      REG_LAMBDA:   lambda_q16 = data[19:0];
      REG_MIN_MULT: min_mult = data;
      default:      max_mult = data;
    endcase
  endtask

  // Send one item; hold start high across back-to-back items, drop it only to idle.
  task automatic send_item(request_t req);
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    apply_item(req);
    if (!no_idle && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 32);
    end
  endtask

  // Hold the sender until every expected result has come and the block is idle.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0 || busy);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic request_t make_item(func_t f, int unsigned sym, logic [31:0] val);
    request_t r;
    r.func = f;
    r.symbol_index = sym[3:0];
    r.return_value = val;
    return r;
  endfunction

  // Returns spread across scales, so sigma lands on both sides of the 0.01 pivot.
  function automatic logic [31:0] random_return();
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 9) == 0) return v;
    v = $signed(v) >>> $urandom_range(2, 12);
    return v;
  endfunction

  // Mostly appends and queries on a few symbols, with clears as noise.
  task automatic random_traffic(int count);
    int unsigned pick;
    func_t f;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 58)      f = FN_APPEND;
      else if (pick < 92) f = FN_QUERY;
      else if (pick < 98) f = FN_CLEAR;
      else                f = FN_CLEAR_ALL;
      send_item(make_item(f, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(0, 3),
                          random_return()));
    end
  endtask

  // Extremes of the fields, every operation, short histories and saturating spread.
  task automatic test_directed();
    send_item(make_item(FN_QUERY, 0, 0));
    send_item(make_item(FN_APPEND, 0, 32'h7FFF_FFFF));
    send_item(make_item(FN_QUERY, 0, 0));
    send_item(make_item(FN_APPEND, 0, 32'h8000_0000));
    send_item(make_item(FN_QUERY, 0, 0));
    send_item(make_item(FN_APPEND, 15, 32'd0));
    send_item(make_item(FN_APPEND, 15, 32'd0));
    send_item(make_item(FN_QUERY, 15, 0));
    send_item(make_item(FN_APPEND, 15, 32'd10_737_418));
    send_item(make_item(FN_QUERY, 15, 0));
    send_item(make_item(FN_CLEAR, 0, 32'hFFFF_FFFF));
    send_item(make_item(FN_QUERY, 0, 0));
    send_item(make_item(FN_CLEAR_ALL, 7, 0));
    send_item(make_item(FN_QUERY, 15, 0));
    for (int i = 0; i < 8; i++)
      send_item(make_item(FN_APPEND, 9, (i % 2) ? 32'h0020_0000 : 32'hFFE0_0000));
    send_item(make_item(FN_QUERY, 9, 32'h5555_5555));
  endtask

  // Window growth, trimming and out-of-range window values.
  task automatic test_window();
    logic [6:0] widths [5] = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd5};
    for (int i = 0; i < 5; i++) begin
      write_reg(REG_WINDOW, {$urandom_range(0, 1) ? 17'h1FFFF : 17'h0, widths[i]});
      random_traffic(120);
    end
    write_reg(REG_WINDOW, 24'd2);
    random_traffic(60);
  endtask

  // Gain and clamp extremes, including crossed clamp bounds.
  task automatic test_gain_clamp();
    write_reg(REG_WINDOW, 24'd8);
    write_reg(REG_LAMBDA, 24'hF00000);
    write_reg(REG_MIN_MULT, 24'd0);
    write_reg(REG_MAX_MULT, 24'hFFFFFF);
    random_traffic(150);
    write_reg(REG_LAMBDA, 24'h0FFFFF);
    random_traffic(150);
    write_reg(REG_MIN_MULT, 24'hFFFFFF);
    write_reg(REG_MAX_MULT, 24'd0);
    random_traffic(100);
    write_reg(REG_MIN_MULT, 24'd60000);
    write_reg(REG_MAX_MULT, 24'd70000);
    write_reg(REG_LAMBDA, 24'd65536);
    random_traffic(150);
  endtask

  // Back-to-back items with the sender never idling.
  task automatic test_no_idle();
    write_reg(REG_WINDOW, 24'd16);
    no_idle = 1'b1;
    random_traffic(300);
    no_idle = 1'b0;
  endtask

  // Random settings; the sender pauses for the results before every change.
  task automatic test_random_settings();
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_WINDOW, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(REG_LAMBDA, 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 8)));
      write_reg(REG_MIN_MULT, 24'($urandom_range(0, 24'h01FFFF)));
      write_reg(REG_MAX_MULT, 24'($urandom_range(24'h010000, 24'hFFFFFF)));
      random_traffic(120);
    end
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: multiplier %0d", result.multiplier);
        mismatches++;
      end else begin
        if (result.multiplier !== expected_results[0].multiplier) begin
          $error("multiplier: expected %0d, got %0d",
                 expected_results[0].multiplier, result.multiplier);
          mismatches++;
        end
        if (result.default_used !== expected_results[0].default_used) begin
          $error("default_used: expected %0d, got %0d",
                 expected_results[0].default_used, result.default_used);
          mismatches++;
        end
        expected_results.delete(0);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    window_len = WINDOW_RST;
    lambda_q16 = LAMBDA_RST;
    min_mult = MIN_MULT_RST;
    max_mult = MAX_MULT_RST;
    for (int i = 0; i < NSYM; i++) begin
      hist_head[i] = 0;
      hist_count[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    random_traffic(200);
    test_window();
    test_gain_clamp();
    test_no_idle();
    test_random_settings();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
